// ===== hw/rtl/multi_policy_process_scheduler_defines.svh =====
// Assertion macros used by the scheduler controller.
// Included by modules that carry concurrent assertions.
`ifndef MULTI_POLICY_PROCESS_SCHEDULER_DEFINES_SVH
`define MULTI_POLICY_PROCESS_SCHEDULER_DEFINES_SVH

// Implication checked on every rising clock edge, off during reset.
`define MPS_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define MPS_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/mps_pkg.sv =====
// Shared types and constants of the scheduler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mps_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_SJF  = 2'd1;
  localparam logic [1:0] POL_RR   = 2'd2;
  localparam logic [1:0] POL_EDF  = 2'd3;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RUN  = 2'd1;
  localparam logic [1:0] PH_OVH  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam logic [1:0] REP_RUN  = 2'd1;
  localparam logic [1:0] REP_DONE = 2'd2;

  localparam logic CMD_ENQ = 1'b1;

  // datapath operations
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_PUSH   = 3'd1; // write tail
  localparam logic [2:0] OP_SHIFT  = 3'd2; // move entry idx to idx-1
  localparam logic [2:0] OP_SCAN   = 3'd3; // compare entry idx with best
  localparam logic [2:0] OP_SWAPA  = 3'd4; // latch head, write best to head
  localparam logic [2:0] OP_SWAPB  = 3'd5; // write saved head to best
  localparam logic [2:0] OP_SAVE   = 3'd6; // latch head into hold
  localparam logic [2:0] OP_PUTTL  = 3'd7; // write hold to idx

  typedef struct packed {
    logic [2:0] op;
    logic       edf;      // scan key is deadline
    logic       rd;       // issue read of idx
    logic       scan_init;
  } dp_cmd_t;
endpackage
`default_nettype wire

// ===== hw/rtl/multi_policy_process_scheduler.sv =====
// Top level of the multi-policy job scheduler: APB registers, controller, datapath.
// Depends on mps_pkg, mps_ctrl and mps_datapath.
//
//   channel   handshake           payload
//   command   start / busy        command, job_id, job_duration, job_deadline, head_report
//   result    done (one cycle)    accepted, finished_*, head_*, queue_count
//   config    APB psel/penable    policy, quantum, overhead
//
// An enqueue is answered from S_OUT; a tick passes S_DEC first if the queue
// holds entries. A retire or rotate shifts each entry by a read and a write,
// a rotation writes the hold to the tail, a scan reads and compares each entry
// and picks the minimum, and a swap exchanges the picked entry with the head.
// Reset is synchronous; it empties the queue and loads register defaults.
// Results show for one cycle on done; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module multi_policy_process_scheduler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command,
  input  wire logic [7:0]  job_id,
  input  wire logic [15:0] job_duration,
  input  wire logic [15:0] job_deadline,
  input  wire logic [1:0]  head_report,
  output logic             done,
  output logic             accepted,
  output logic             finished_valid,
  output logic [7:0]       finished_id,
  output logic             head_valid,
  output logic [7:0]       head_id,
  output logic [1:0]       head_phase,
  output logic [4:0]       queue_count,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_QUANTUM = 2'd1;
  localparam logic [1:0] REG_OVERHEAD = 2'd2;

  logic [1:0] policy;
  logic [7:0] quantum, overhead;
  logic       wr;
  logic       pol_we;
  mps_pkg::dp_cmd_t cmd;
  logic [mps_pkg::IW-1:0] idx, best;
  logic [7:0] mem_head;
  mps_pkg::dp_cmd_t dcmd;
  logic [mps_pkg::IW-1:0] didx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign pol_we = wr && paddr[3:2] == REG_POLICY;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= mps_pkg::POL_FIFO;
      quantum <= 8'd2;
      overhead <= 8'd1;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_POLICY:   policy <= pwdata[1:0];
        REG_QUANTUM:  quantum <= pwdata[7:0];
        REG_OVERHEAD: overhead <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_POLICY:   prdata = {30'd0, policy};
      REG_QUANTUM:  prdata = {24'd0, quantum};
      REG_OVERHEAD: prdata = {24'd0, overhead};
      default:      prdata = 32'd0;
    endcase
  end

  // swap read of best entry happens in the same slot as the wait state
  always_comb begin
    dcmd = cmd;
    didx = idx;
    if (cmd.op == mps_pkg::OP_NONE && !cmd.rd && busy && best != '0) begin
      dcmd.rd = 1'b1;
      didx = best;
    end
  end

  mps_ctrl u_ctrl (
    .clk, .rst, .start, .command, .head_report,
    .cfg_pol_we(pol_we), .policy, .quantum, .overhead,
    .best, .head_id(mem_head),
    .cmd, .idx, .busy, .done, .accepted, .finished_valid, .finished_id,
    .head_valid, .head_id_o(head_id), .head_phase, .queue_count
  );

  mps_datapath u_dp (
    .clk, .cmd(dcmd), .idx(didx), .in_id(job_id), .in_dur(job_duration),
    .in_dl(job_deadline), .best, .head_id(mem_head)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/mps_datapath.sv =====
// Queue memory, hold register and minimum-search unit of the scheduler.
// Depends on mps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mps_datapath (
  input  wire logic                   clk,
  input  wire mps_pkg::dp_cmd_t       cmd,
  input  wire logic [mps_pkg::IW-1:0] idx,
  input  wire logic [7:0]             in_id,
  input  wire logic [15:0]            in_dur,
  input  wire logic [15:0]            in_dl,
  output logic [mps_pkg::IW-1:0]      best,
  output logic [7:0]                  head_id
);
  localparam int IW = mps_pkg::IW;

  logic [7:0]  mem_id [mps_pkg::QUEUE_DEPTH];
  logic [15:0] mem_du [mps_pkg::QUEUE_DEPTH];
  logic [15:0] mem_dl [mps_pkg::QUEUE_DEPTH];
  logic [7:0]  r_id;
  logic [15:0] r_du, r_dl;
  logic [IW-1:0] r_idx;
  logic [7:0]  h_id;
  logic [15:0] h_du, h_dl;
  logic [7:0]  b_id;
  logic [15:0] b_key;
  logic [15:0] r_key;
  logic        better;
  logic [IW-1:0] wa;
  logic        we;
  logic [7:0]  w_id;
  logic [15:0] w_du, w_dl;

  assign r_key = cmd.edf ? r_dl : r_du;
  assign better = cmd.edf ? ((r_key < b_key) || (r_key == b_key && r_id < b_id))
                          : (r_key < b_key);

  always_comb begin
    we = 1'b0;
    wa = idx;
    w_id = r_id;
    w_du = r_du;
    w_dl = r_dl;
    unique case (cmd.op) inside
      mps_pkg::OP_PUSH: begin
        we = 1'b1; w_id = in_id; w_du = in_dur; w_dl = in_dl;
      end
      mps_pkg::OP_SHIFT: begin
        we = 1'b1; wa = r_idx - IW'(1);
      end
      mps_pkg::OP_SWAPA: begin
        we = 1'b1; wa = '0;
      end
      mps_pkg::OP_SWAPB, mps_pkg::OP_PUTTL: begin
        we = 1'b1; w_id = h_id; w_du = h_du; w_dl = h_dl;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_id[wa] <= w_id;
      mem_du[wa] <= w_du;
      mem_dl[wa] <= w_dl;
    end
    if (cmd.rd) begin
      r_id <= mem_id[idx];
      r_du <= mem_du[idx];
      r_dl <= mem_dl[idx];
      r_idx <= idx;
    end
    if (cmd.op == mps_pkg::OP_SAVE || cmd.op == mps_pkg::OP_SWAPA) begin
      h_id <= head_id;
      h_du <= mem_du[0];
      h_dl <= mem_dl[0];
    end
    if (cmd.scan_init) begin
      best <= r_idx; b_id <= r_id; b_key <= r_key;
    end else if (cmd.op == mps_pkg::OP_SCAN && better) begin
      best <= r_idx; b_id <= r_id; b_key <= r_key;
    end
  end

  assign head_id = mem_id[0];
endmodule
`default_nettype wire

// ===== hw/rtl/mps_ctrl.sv =====
// Controller state machine of the scheduler: policy decisions and sequencing.
// Depends on mps_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_policy_process_scheduler_defines.svh"
module mps_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic                   command,
  input  wire logic [1:0]             head_report,
  input  wire logic                   cfg_pol_we,
  input  wire logic [1:0]             policy,
  input  wire logic [7:0]             quantum,
  input  wire logic [7:0]             overhead,
  input  wire logic [mps_pkg::IW-1:0] best,
  input  wire logic [7:0]             head_id,
  output mps_pkg::dp_cmd_t            cmd,
  output logic [mps_pkg::IW-1:0]      idx,
  output logic                        busy,
  output logic                        done,
  output logic                        accepted,
  output logic                        finished_valid,
  output logic [7:0]                  finished_id,
  output logic                        head_valid,
  output logic [7:0]                  head_id_o,
  output logic [1:0]                  head_phase,
  output logic [4:0]                  queue_count
);
  localparam int QUEUE_DEPTH = mps_pkg::QUEUE_DEPTH;
  localparam int IW = mps_pkg::IW;
  localparam int CW = mps_pkg::CW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_SHRD   = 4'd2;  // read entry for shift
  localparam logic [3:0] S_SHWR   = 4'd3;  // write shifted entry
  localparam logic [3:0] S_TAIL   = 4'd4;  // rotate: put hold at tail
  localparam logic [3:0] S_SCRD   = 4'd5;
  localparam logic [3:0] S_SCCMP  = 4'd6;
  localparam logic [3:0] S_SWA    = 4'd7;
  localparam logic [3:0] S_SWB    = 4'd8;
  localparam logic [3:0] S_SWRD   = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0]    state, state_next;
  logic [CW-1:0] count;
  logic [1:0]    hst;
  logic [7:0]    slice_left, switch_left;
  logic [CW-1:0] ptr;
  logic          rot;       // shift is a rotation
  logic          post_scan; // after retire, run a scan
  logic          scan_edf;
  logic          acc_r, fin_v;
  logic [7:0]    fin_id;
  logic          out_r;
  logic [1:0]    hst_eff;
  logic [7:0]    reload;

  assign reload = quantum - 8'd1;
  assign busy = (state != S_IDLE);
  assign done = out_r;
  assign accepted = acc_r;
  assign finished_valid = fin_v;
  assign finished_id = fin_v ? fin_id : 8'd0;
  assign head_valid = (count != '0);
  assign head_id_o = (count != '0) ? head_id : 8'd0;
  assign head_phase = (count != '0) ? hst : mps_pkg::PH_IDLE;
  assign queue_count = 5'(count);
  assign idx = (state == S_IDLE) ? count[IW-1:0] : ptr[IW-1:0];

  always_comb begin
    hst_eff = hst;
    if (head_report == mps_pkg::REP_RUN) hst_eff = mps_pkg::PH_RUN;
    else if (head_report == mps_pkg::REP_DONE) hst_eff = mps_pkg::PH_DONE;
  end

  always_comb begin
    cmd = '0;
    cmd.edf = scan_edf;
    unique case (state)
      S_SHRD: cmd.rd = 1'b1;
      S_SHWR: cmd.op = mps_pkg::OP_SHIFT;
      S_TAIL: cmd.op = mps_pkg::OP_PUTTL;
      S_SCRD: cmd.rd = 1'b1;
      S_SCCMP: begin
        cmd.op = mps_pkg::OP_SCAN;
        cmd.scan_init = (ptr == '0);
      end
      S_SWA: cmd.op = mps_pkg::OP_SWAPA;
      S_SWB: cmd.op = mps_pkg::OP_SWAPB;
      default: cmd.op = mps_pkg::OP_NONE;
    endcase
    if (state == S_IDLE && start && command == mps_pkg::CMD_ENQ
        && count != CW'(QUEUE_DEPTH))
      cmd.op = mps_pkg::OP_PUSH;
    if (state == S_DEC) cmd.op = mps_pkg::OP_SAVE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      hst <= mps_pkg::PH_IDLE;
      slice_left <= '0;
      switch_left <= '0;
      out_r <= 1'b0;
      ptr <= '0;
      rot <= 1'b0;
      post_scan <= 1'b0;
      scan_edf <= 1'b0;
      acc_r <= 1'b0;
      fin_v <= 1'b0;
      fin_id <= '0;
    end else begin
      out_r <= 1'b0;
      if (cfg_pol_we) begin
        slice_left <= '0;
        switch_left <= '0;
        hst <= mps_pkg::PH_IDLE;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            acc_r <= 1'b1;
            fin_v <= 1'b0;
            post_scan <= 1'b0;
            if (command == mps_pkg::CMD_ENQ) begin
              if (count != CW'(QUEUE_DEPTH)) begin
                count <= count + CW'(1);
                ptr <= count;
              end else acc_r <= 1'b0;
              state <= S_OUT;
            end else if (count == '0) begin
              state <= S_OUT;
            end else begin
              hst <= hst_eff;
              state <= S_DEC;
            end
          end
        end
        S_DEC: begin
          state <= S_OUT;
          scan_edf <= (policy == mps_pkg::POL_EDF);
          rot <= 1'b0;
          ptr <= CW'(1);
          if (policy == mps_pkg::POL_FIFO || policy == mps_pkg::POL_SJF) begin
            if (hst == mps_pkg::PH_DONE) begin
              fin_v <= 1'b1; fin_id <= head_id;
              hst <= mps_pkg::PH_IDLE;
              post_scan <= (policy == mps_pkg::POL_SJF);
              state <= S_SHRD;
            end else if (policy == mps_pkg::POL_SJF && hst == mps_pkg::PH_IDLE
                         && count > CW'(1)) begin
              ptr <= '0; state <= S_SCRD;
            end
          end else if (hst == mps_pkg::PH_DONE) begin
            fin_v <= 1'b1; fin_id <= head_id;
            hst <= mps_pkg::PH_IDLE;
            post_scan <= (policy == mps_pkg::POL_EDF);
            slice_left <= (count > CW'(1)) ? reload : 8'd0;
            state <= S_SHRD;
          end else if (slice_left != 8'd0) begin
            slice_left <= slice_left - 8'd1;
          end else if (hst == mps_pkg::PH_IDLE) begin
            slice_left <= reload;
            if (policy == mps_pkg::POL_EDF && count > CW'(1)) begin
              ptr <= '0; state <= S_SCRD;
            end
          end else if (hst == mps_pkg::PH_RUN) begin
            hst <= mps_pkg::PH_OVH;
            switch_left <= overhead - 8'd1;
          end else if (switch_left != 8'd0) begin
            switch_left <= switch_left - 8'd1;
          end else begin
            hst <= mps_pkg::PH_IDLE;
            slice_left <= reload;
            if (count > CW'(1)) begin
              if (policy == mps_pkg::POL_EDF) begin
                ptr <= '0; state <= S_SCRD;
              end else begin
                rot <= 1'b1; state <= S_SHRD;
              end
            end
          end
        end
        S_SHRD: begin
          if (ptr == count) begin
            if (rot) begin
              ptr <= count - CW'(1); state <= S_TAIL;
            end else begin
              count <= count - CW'(1);
              if (post_scan && count > CW'(2)) begin
                ptr <= '0; state <= S_SCRD;
              end else state <= S_OUT;
            end
          end else state <= S_SHWR;
        end
        S_SHWR: begin
          ptr <= ptr + CW'(1);
          state <= S_SHRD;
        end
        S_TAIL: state <= S_OUT;
        S_SCRD: state <= S_SCCMP;
        S_SCCMP: begin
          if (ptr == count - CW'(1)) state <= S_SWRD;
          else begin
            ptr <= ptr + CW'(1); state <= S_SCRD;
          end
        end
        S_SWRD: begin
          if (best == '0) state <= S_OUT;
          else begin
            ptr <= CW'(best); state <= S_SWA;
          end
        end
        S_SWA: state <= S_SWB;
        S_SWB: state <= S_OUT;
        S_OUT: begin
          out_r <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // S_SWA needs the entry at best in the read register: the data path swap writes it to the head
  // the read is issued during S_SWRD by the top level, which steers idx to best
  `MPS_ASSERT_IMP(a_cnt_range, clk, rst, 1'b1, count <= CW'(QUEUE_DEPTH))
  `MPS_ASSERT_NEXT(a_done_pulse, clk, rst, out_r, !out_r)
  `MPS_ASSERT_NEXT(a_out_idle, clk, rst, state == S_OUT, state == S_IDLE && out_r)
  `MPS_ASSERT_IMP(a_fin_tick, clk, rst, out_r && fin_v, acc_r)
endmodule
`default_nettype wire
